// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file olt_checker.sv
// no dependencies; each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OLT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/olt_pkg.sv =====
// shared types, constants and helpers of the ordered list table
// no dependencies
package olt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IN_KEY_W  = 32;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CFG_IDX_W = 2;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT_OUT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REMOVE
  } state_e;

  localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_REPEATS = CFG_IDX_W'(1);

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_e  cmd;
    func_e func;
    logic  sorted;
  } cell_ctl_t;

  // summary gathered from the chain
  typedef struct packed {
    logic             any_match;
    logic [CNT_W-1:0] position;
  } chain_stat_t;

  // low KEY_WIDTH bits of the port key, two's complement
  function automatic key_t to_key(input logic [IN_KEY_W-1:0] raw);
    return key_t'(signed'(raw));
  endfunction

endpackage

// ===== sv/olt_ifs.sv =====
// handshake channels of the ordered list table: items in, results out, config writes
// depends on olt_pkg
interface olt_in_if import olt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [IN_KEY_W-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface olt_out_if import olt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] removed_count;
  logic [OUT_CNT_W-1:0] position;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 empty_res;

  modport source (output valid, status, removed_count, position, entry_count, empty_res,
                  input ready);
  modport sink   (input valid, status, removed_count, position, entry_count, empty_res,
                  output ready);
endinterface

interface olt_cfg_if import olt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic                 wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/olt_cell.sv =====
// one slot of the list: key, occupancy bit and the compare against the broadcast key
// depends on olt_pkg
module olt_cell import olt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  key_t      key_i,
  input  key_t      left_entry_i,
  input  logic      left_valid_i,
  input  key_t      right_entry_i,
  input  logic      right_valid_i,
  input  logic      before_i,
  output key_t      entry_o,
  output logic      valid_o,
  output logic      before_o,
  output logic      match_o,
  output logic      pos_bit_o
);

  key_t entry_q, entry_d;
  logic valid_q, valid_d;
  logic eq, gt, ge, hit;

  always_comb begin
    eq = valid_q && (entry_q == key_i);
    gt = valid_q && (entry_q > key_i);
    ge = gt || eq;
    unique case (ctl_i.func)
      FUNC_INSERT: hit = !valid_q || (ctl_i.sorted ? gt : eq);
      FUNC_SEARCH: hit = ctl_i.sorted ? ge : eq;
      FUNC_REMOVE: hit = eq;
      default:     hit = 1'b0;
    endcase
  end

  assign before_o  = before_i || hit;
  assign match_o   = eq;
  assign pos_bit_o = valid_q && !(before_i || hit);
  assign entry_o   = entry_q;
  assign valid_o   = valid_q;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    unique case (ctl_i.cmd)
      CMD_INSERT: begin
        // cells past the insert point take the left neighbor
        if (before_i) begin
          entry_d = left_entry_i;
          valid_d = left_valid_i;
        end else if (hit) begin
          entry_d = key_i;
          valid_d = 1'b1;
        end
      end
      CMD_SHIFT_OUT: begin
        // first match and everything after it pull from the right
        if (before_i || hit) begin
          entry_d = right_entry_i;
          valid_d = right_valid_i;
        end
      end
      CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/olt_chain.sv =====
// row of CAPACITY cells with neighbor links and the match and position summary
// depends on olt_pkg and olt_cell
module olt_chain import olt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  key_t        key_i,
  output chain_stat_t stat_o
);

  key_t                entry [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY:0]   passed;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pos_bit;

  assign passed[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_entry, right_entry;
    logic left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = key_i;
      assign left_valid = 1'b0;
    end else begin : g_link_l
      assign left_entry = entry[i-1];
      assign left_valid = valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = key_i;
      assign right_valid = 1'b0;
    end else begin : g_link_r
      assign right_entry = entry[i+1];
      assign right_valid = valid[i+1];
    end

    olt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .key_i        (key_i),
      .left_entry_i (left_entry),
      .left_valid_i (left_valid),
      .right_entry_i(right_entry),
      .right_valid_i(right_valid),
      .before_i     (passed[i]),
      .entry_o      (entry[i]),
      .valid_o      (valid[i]),
      .before_o     (passed[i+1]),
      .match_o      (match[i]),
      .pos_bit_o    (pos_bit[i])
    );
  end

  assign stat_o.any_match = |match;
  assign stat_o.position  = CNT_W'($countones(pos_bit));

endmodule

// ===== sv/ordered_list_table_unit.sv =====
// ordered list table: insert, remove-all-matches and search on up to CAPACITY signed keys
// insert, search and unused codes register their result in ST_EXEC once the output is free
// remove goes on to ST_REMOVE, one matching entry shifted out a cycle, then gives the result
// one item in flight; next item taken once control is idle
// reset: asynchronous active low, list empty, sorted_mode = 1, allow_repeats = 1
// depends on olt_pkg, olt_ifs and olt_chain
module ordered_list_table_unit import olt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  olt_cfg_if.sink   cfg_i,
  olt_in_if.sink    in_i,
  olt_out_if.source out_o
);

  // control and config registers
  state_e           state_q, state_d;
  func_e            func_q;
  key_t             key_q;
  logic             sorted_q;
  logic             repeats_q;
  logic [CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] rm_cnt_q, rm_cnt_d;

  // result register, parts the two sides
  logic                 out_valid_q;
  status_e              status_q;
  logic [OUT_CNT_W-1:0] removed_q;
  logic [OUT_CNT_W-1:0] position_q;
  logic [OUT_CNT_W-1:0] count_q;
  logic                 empty_q;

  // result being formed this cycle
  logic             res_load;
  status_e          res_status;
  logic [CNT_W-1:0] res_removed;
  logic [CNT_W-1:0] res_pos;

  logic        out_free;
  cell_ctl_t   ctl;
  chain_stat_t stat;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;

  olt_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .key_i (key_q),
    .stat_o(stat)
  );

  // sequencer: compare in the cells, then commit the shift and the result
  always_comb begin
    state_d     = state_q;
    ctl.cmd     = CMD_HOLD;
    ctl.func    = func_q;
    ctl.sorted  = sorted_q;
    held_d      = held_q;
    rm_cnt_d    = rm_cnt_q;
    res_load    = 1'b0;
    res_status  = STAT_OK;
    res_removed = '0;
    res_pos     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_q)
          FUNC_INSERT: begin
            if (out_free) begin
              // duplicate check wins over full
              priority if (!repeats_q && stat.any_match) begin
                res_status = STAT_DUP;
              end else if (held_q == CNT_W'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                ctl.cmd = CMD_INSERT;
                held_d  = held_q + CNT_W'(1);
              end
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          FUNC_REMOVE: begin
            rm_cnt_d = '0;
            state_d  = ST_REMOVE;
          end
          FUNC_SEARCH: begin
            if (out_free) begin
              res_pos  = stat.position;
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            // unused code, no change to the list
            if (out_free) begin
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end
      ST_REMOVE: begin
        // drop the first match each cycle until none is left
        if (stat.any_match) begin
          ctl.cmd  = CMD_SHIFT_OUT;
          held_d   = held_q - CNT_W'(1);
          rm_cnt_d = rm_cnt_q + CNT_W'(1);
        end else if (out_free) begin
          res_removed = rm_cnt_q;
          res_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sorted_q    <= 1'b1;
      repeats_q   <= 1'b1;
      held_q      <= '0;
      rm_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      rm_cnt_q <= rm_cnt_d;
      if (cfg_i.valid) begin
        if (cfg_i.reg_index == REG_SORTED_MODE) begin
          sorted_q <= cfg_i.wdata;
        end
        if (cfg_i.reg_index == REG_ALLOW_REPEATS) begin
          repeats_q <= cfg_i.wdata;
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= func_e'(in_i.func);
      key_q  <= to_key(in_i.key);
    end
    if (res_load) begin
      status_q   <= res_status;
      removed_q  <= OUT_CNT_W'(res_removed);
      position_q <= OUT_CNT_W'(res_pos);
      count_q    <= OUT_CNT_W'(held_d);
      empty_q    <= (held_d == '0);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_count = removed_q;
  assign out_o.position      = position_q;
  assign out_o.entry_count   = count_q;
  assign out_o.empty_res     = empty_q;

endmodule

// ===== sv/olt_checker.sv =====
// port-level checks on the result channel of ordered_list_table_unit, bound to the top level
// depends on olt_pkg and assert_macros.svh
`include "assert_macros.svh"

module olt_checker import olt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           status,
  input logic [OUT_CNT_W-1:0] removed_count,
  input logic [OUT_CNT_W-1:0] position,
  input logic [OUT_CNT_W-1:0] entry_count,
  input logic                 empty_res
);

  `OLT_ASSERT_SAME(a_empty_flag, out_valid, empty_res == (entry_count == '0), "empty flag disagrees with count")
  `OLT_ASSERT_SAME(a_reject_clean, out_valid && status != STAT_OK, removed_count == '0 && position == '0, "rejected insert reports removal or position")
  `OLT_ASSERT_SAME(a_full_count, out_valid && status == STAT_FULL, entry_count == OUT_CNT_W'(CAPACITY), "full status while list not full")
  `OLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count), "stalled result changed")

endmodule

bind ordered_list_table_unit olt_checker u_olt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .status       (out_o.status),
  .removed_count(out_o.removed_count),
  .position     (out_o.position),
  .entry_count  (out_o.entry_count),
  .empty_res    (out_o.empty_res)
);

// ===== dv/olt_list_checker.sv =====
// checker for the ordered list table: watches config, item and result channels
// predicts each result from its own copy of the list and compares field by field
// depends on olt_pkg and olt_ifs
module olt_list_checker import olt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  olt_cfg_if   cfg_mon,
  olt_in_if    in_mon,
  olt_out_if   out_mon,
  output int   fail_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] removed;
    logic [OUT_CNT_W-1:0] position;
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } list_result_t;

  key_t         list_keys [CAPACITY];
  int           list_len;
  logic         sorted_q;
  logic         repeats_q;
  list_result_t pending_results [$];
  list_result_t want;
  int           fail_n = 0;
  int           pending_n = 0;

  assign fail_count_o  = fail_n;
  assign outstanding_o = pending_n;

  // applies one operation to the local list and returns the result it gives
  function automatic list_result_t apply_list_op(input logic [1:0] op, input key_t k);
    list_result_t r;
    int           stop;
    int           w;
    int           removed;
    logic         dup;
    r       = '0;
    stop    = list_len;
    removed = 0;
    dup     = 1'b0;
    case (op)
      FUNC_INSERT: begin
        if (!repeats_q) begin
          for (int i = 0; i < list_len; i++) if (list_keys[i] == k) dup = 1'b1;
        end
        if (dup) begin
          r.status = STAT_DUP;
        end else if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (sorted_q ? (list_keys[i] > k) : (list_keys[i] == k)) begin
              stop = i;
              break;
            end
          end
          for (int j = list_len; j > stop; j--) list_keys[j] = list_keys[j-1];
          list_keys[stop] = k;
          list_len++;
          r.status = STAT_OK;
        end
      end
      FUNC_REMOVE: begin
        w = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_keys[i] == k) begin
            removed++;
          end else begin
            list_keys[w] = list_keys[i];
            w++;
          end
        end
        list_len  = w;
        r.removed = OUT_CNT_W'(removed);
      end
      FUNC_SEARCH: begin
        for (int i = 0; i < list_len; i++) begin
          if (sorted_q ? (list_keys[i] >= k) : (list_keys[i] == k)) begin
            stop = i;
            break;
          end
        end
        r.position = OUT_CNT_W'(stop);
      end
      default: ;
    endcase
    r.count = OUT_CNT_W'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len  = 0;
      sorted_q  = 1'b1;
      repeats_q = 1'b1;
      pending_results.delete();
      pending_n = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d count %0d", $time,
                   out_mon.status, out_mon.entry_count);
          fail_n++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("removed_count", want.removed, out_mon.removed_count);
          check_field("position", want.position, out_mon.position);
          check_field("entry_count", want.count, out_mon.entry_count);
          check_field("empty_res", want.empty, out_mon.empty_res);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_SORTED_MODE) sorted_q = cfg_mon.wdata;
        else if (cfg_mon.reg_index == REG_ALLOW_REPEATS) repeats_q = cfg_mon.wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_list_op(in_mon.func, $signed(in_mon.key)));
      end
      pending_n = pending_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// top of the ordered list table testbench: clock, reset, stimulus and verdict
// depends on olt_pkg, olt_ifs, ordered_list_table_unit and olt_list_checker
module testbench import olt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // func code the block treats as no operation
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam key_t       KEY_MIN       = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam key_t       KEY_MAX       = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  // covers the worst remove: one shift per matching entry, then the result
  localparam int         SETTLE_CYCLES = 20;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 200;
  localparam int         STALL_CYCLES  = 300;

  logic clk;
  logic rst_n;

  olt_in_if  in_ch ();
  olt_out_if out_ch ();
  olt_cfg_if cfg_ch ();

  int fail_count;
  int outstanding;

  // idling knobs, written by the stimulus process only
  int send_busy_pct;
  int recv_busy_pct;
  int stall_trigger;

  key_t key_pool [6];

  ordered_list_table_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  olt_list_checker list_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_mon       (cfg_ch),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one item after an optional gap, hold it until taken
  task automatic send_item(input logic [1:0] op, input key_t k);
    int gap;
    gap = ($urandom_range(0, 99) < send_busy_pct) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= op;
    in_ch.key   <= k;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every expected result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // pool keys collide often, so removes and duplicate checks have work to do
  function automatic key_t pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 5)];
    return key_t'($urandom());
  endfunction

  // result side: random gaps plus one long hold-off per trigger
  initial begin : recv_side
    int hold_left;
    int idle_left;
    int stall_seen;
    hold_left    = 0;
    idle_left    = 0;
    stall_seen   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_trigger != stall_seen) begin
        stall_seen = stall_trigger;
        hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_busy_pct) idle_left = gap_len();
      end
    end
  end

  initial begin : stimulus
    // per phase: sorted mode, repeats, insert and remove share in percent
    logic  ph_sorted [PHASES];
    logic  ph_repeat [PHASES];
    int    ph_ins    [PHASES];
    int    ph_rem    [PHASES];
    int    r;
    logic [1:0] op;

    ph_sorted = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    ph_repeat = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    ph_ins    = '{75, 70, 45, 75, 35, 50, 40, 60};
    ph_rem    = '{10, 10, 30, 10, 45, 25, 35, 20};

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_INSERT;
    in_ch.key        = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_SORTED_MODE;
    cfg_ch.wdata     = 1'b0;
    send_busy_pct    = 30;
    recv_busy_pct    = 30;
    stall_trigger    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset config: sorted with repeats
    send_item(FUNC_SEARCH, 32'sd5);        // search on an empty list
    send_item(FUNC_REMOVE, 32'sd5);        // remove on an empty list
    send_item(FUNC_INSERT, KEY_MAX);
    send_item(FUNC_INSERT, KEY_MIN);
    send_item(FUNC_INSERT, 32'sd0);
    send_item(FUNC_INSERT, 32'sd0);        // repeat allowed
    send_item(FUNC_INSERT, -32'sd1);
    send_item(FUNC_SEARCH, 32'sd0);
    send_item(FUNC_SEARCH, KEY_MAX);
    send_item(FUNC_SEARCH, 32'sd7);
    send_item(FUNC_UNUSED, -32'sd1);       // no operation code
    send_item(FUNC_REMOVE, 32'sd0);        // two matches
    send_item(FUNC_REMOVE, 32'sd12345);    // no match
    send_item(FUNC_SEARCH, KEY_MIN);

    // insertion order, duplicates rejected; list built sorted is scanned unsorted
    wait_drained();
    write_reg(REG_SORTED_MODE, 1'b0);
    write_reg(REG_ALLOW_REPEATS, 1'b0);
    send_item(FUNC_INSERT, 32'sh55555555);
    send_item(FUNC_INSERT, 32'shAAAAAAAA);
    send_item(FUNC_INSERT, KEY_MAX);       // duplicate rejected
    send_item(FUNC_SEARCH, KEY_MIN);
    send_item(FUNC_SEARCH, 32'sd99);       // absent: position is the count
    send_item(FUNC_REMOVE, KEY_MAX);
    send_item(FUNC_REMOVE, KEY_MIN);
    send_item(FUNC_REMOVE, -32'sd1);
    send_item(FUNC_REMOVE, 32'sh55555555);
    send_item(FUNC_REMOVE, 32'shAAAAAAAA); // list empty again

    // random phases; the list carries over between them, so scans see lists
    // built in the other mode and duplicate inserts meet a full list
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_SORTED_MODE, ph_sorted[p]);
      write_reg(REG_ALLOW_REPEATS, ph_repeat[p]);
      key_pool      = '{KEY_MIN, KEY_MAX, 32'sd0, -32'sd1,
                        key_t'($urandom()), key_t'($urandom_range(0, 7))};
      send_busy_pct = (p == 2) ? 0 : 30;
      recv_busy_pct = (p == 2) ? 0 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 60 && (p == 0 || p == 5)) stall_trigger++;
        r = $urandom_range(0, 99);
        if (r < ph_ins[p]) op = FUNC_INSERT;
        else if (r < ph_ins[p] + ph_rem[p]) op = FUNC_REMOVE;
        else if (r < 97) op = FUNC_SEARCH;
        else op = FUNC_UNUSED;
        send_item(op, pick_key());
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== ordered_list_table_unit.f =====
+incdir+sv
sv/olt_pkg.sv
sv/olt_ifs.sv
sv/olt_cell.sv
sv/olt_chain.sv
sv/ordered_list_table_unit.sv
sv/olt_checker.sv
dv/olt_list_checker.sv
dv/testbench.sv
